// ===== sv/bba_pkg.sv =====
// bba_pkg: shared types and constants for the bitmap block allocator
// no dependencies; imported by the allocator top and its checker

package bba_pkg;

   // default geometry of the bitmap
   localparam int unsigned TOTAL_BLOCKS_DEF  = 65536;
   localparam int unsigned USABLE_BLOCKS_DEF = 65520;
   localparam int unsigned WORD_BITS_DEF     = 64;

   // one summary word holds the full flags of 64 bitmap words
   localparam int unsigned SUM_BITS    = 64;
   localparam int unsigned SUM_SEL_W   = 6;

   // field widths of the request and response
   localparam int unsigned ID_W        = 16;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned USED_W      = 17;
   localparam int unsigned FREE_W      = 16;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 56;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_CLAIM = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NONE_FREE = 2'd1,
      STAT_IN_USE    = 2'd2,
      STAT_RANGE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_REM,
      S_UPD,
      S_SUM_RD,
      S_SUM_CHK,
      S_WRD_RD,
      S_WRD_CHK,
      S_FIN
   } state_type;

endpackage

// ===== sv/bba_ram.sv =====
// bba_ram: generic single-port ram with registered read data
// depends on nothing; used for the bitmap and its summary

module bba_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== sv/bba_find_zero.sv =====
// bba_find_zero: priority encoder for the lowest clear bit of a word
// depends on nothing; used on summary words and bitmap words

module bba_find_zero #(
   parameter int unsigned WIDTH = 64,
   localparam int unsigned IW   = (WIDTH > 1) ? $clog2(WIDTH) : 1
)(
   input  logic [WIDTH-1:0] word,
   output logic             found,
   output logic [IW-1:0]    idx
);

   always_comb begin
      idx = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = IW'(i);
         end
      end
   end

   assign found = ~&word;

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// bitmap_block_allocator: free-block bitmap with allocate, claim and release
// steps from request accept: allocate reads and checks summary words, then one bitmap word;
// claim or release divides, takes the remainder, updates; out-of-range id or nop finishes
// a new request is taken only once back in idle, which waits while a response stalls
// reset: synchronous, active high; then a clearing pass of one bitmap word per cycle
// (1024 words by default) writes the reserved pattern, with req_tready low meanwhile

module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int unsigned TOTAL_BLOCKS  = TOTAL_BLOCKS_DEF,
   parameter int unsigned USABLE_BLOCKS = USABLE_BLOCKS_DEF,
   parameter int unsigned WORD_BITS     = WORD_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] blk_num
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] granted_id, [32:16] used_count,
                                              // [48:33] free_count, [55:49] zero
   output logic [STATUS_W-1:0]   rsp_tuser    // [1:0] status
);

   // geometry
   localparam int unsigned EFF       = (USABLE_BLOCKS < TOTAL_BLOCKS) ?
                                       USABLE_BLOCKS : TOTAL_BLOCKS;
   localparam int unsigned NUM_WORDS = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned SUM_DEPTH = (NUM_WORDS + SUM_BITS - 1) / SUM_BITS;
   localparam int unsigned SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
   localparam int unsigned WEXT_W    = SUM_AW + SUM_SEL_W;
   localparam int unsigned BIT_W     = $clog2(WORD_BITS);
   // first bitmap word whose bits are all reserved (or past the end)
   localparam int unsigned FFW       = (EFF + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned BASE_W    = $clog2(TOTAL_BLOCKS + WORD_BITS);
   localparam int unsigned CNT_W     = $clog2(TOTAL_BLOCKS + 1);
   localparam int unsigned MUL_W     = WEXT_W + BIT_W + 1;
   // id / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 16-bit ids
   localparam int unsigned DIV_SH    = ID_W + BIT_W;
   localparam int unsigned RECIP_W   = ID_W + 2;
   localparam int unsigned PROD_W    = ID_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH) / WORD_BITS) + 1);
   localparam int unsigned PAD_W     = RSP_DATA_W - ID_W - USED_W - FREE_W;

   // state
   state_type             state_ff, state_in;
   logic [WIDX_W-1:0]     clr_ff, clr_in;         // clearing pass word index
   logic [BASE_W-1:0]     base_ff, base_in;       // first block id of word clr_ff
   cmd_type               cmd_ff, cmd_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [WEXT_W-1:0]     wext_ff, wext_in;       // bitmap word index {summary, slot}
   logic [BIT_W-1:0]      bit_ff, bit_in;         // bit within the bitmap word
   logic [BASE_W-1:0]     prod_ff, prod_in;       // first block id of the found word
   logic [SUM_BITS-1:0]   sum_ff, sum_in;         // summary word seen by the scan
   logic [SUM_AW-1:0]     scan_ff, scan_in;       // summary scan pointer
   logic [SUM_AW-1:0]     hint_ff, hint_in;       // all summary words below are full
   logic [CNT_W-1:0]      cnt_ff, cnt_in;         // set bits, reserved included
   status_type            status_ff, status_in;
   logic [ID_W-1:0]       grant_ff, grant_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   // ram ports
   logic                  bm_we;
   logic [WIDX_W-1:0]     bm_addr;
   logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
   logic                  sum_we;
   logic [SUM_AW-1:0]     sum_addr;
   logic [SUM_BITS-1:0]   sum_wdata, sum_rdata;

   // datapath helpers
   logic                  accept;
   logic                  in_range;
   logic                  rsp_free;
   logic                  scan_last;
   logic                  fz_sum_found, fz_wrd_found;
   logic [SUM_SEL_W-1:0]  fz_sum_idx;
   logic [BIT_W-1:0]      fz_wrd_idx;
   logic [PROD_W-1:0]     div_prod;
   logic [PROD_W-1:0]     div_quot;
   logic [MUL_W-1:0]      wmul;
   logic [ID_W-1:0]       rem_full;
   logic [BIT_W-1:0]      bit_sel;
   logic [WORD_BITS-1:0]  bit_mask, word_set, word_clr;
   logic [SUM_BITS-1:0]   slot_mask;
   logic [SUM_AW-1:0]     wext_sum;
   logic [WORD_BITS-1:0]  init_word;
   logic [SUM_BITS-1:0]   init_sum;
   logic [CNT_W-1:0]      free_full;
   logic [CNT_W+USED_W-1:0] used_ext;
   logic [CNT_W+FREE_W-1:0] free_ext;
   logic                  cur_bit;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .addr  (bm_addr),
      .wdata (bm_wdata),
      .rdata (bm_rdata)
   );

   bba_ram #(.WIDTH(SUM_BITS), .DEPTH(SUM_DEPTH)) u_summary (
      .clock (clock),
      .we    (sum_we),
      .addr  (sum_addr),
      .wdata (sum_wdata),
      .rdata (sum_rdata)
   );

   // lowest non-full bitmap word within a summary word
   bba_find_zero #(.WIDTH(SUM_BITS)) u_fz_sum (
      .word  (sum_rdata),
      .found (fz_sum_found),
      .idx   (fz_sum_idx)
   );

   // lowest free block within a bitmap word
   bba_find_zero #(.WIDTH(WORD_BITS)) u_fz_wrd (
      .word  (bm_rdata),
      .found (fz_wrd_found),
      .idx   (fz_wrd_idx)
   );

   assign accept    = req_tvalid && req_tready;
   assign in_range  = (32'(req_tdata) < 32'(EFF));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign scan_last = (scan_ff == SUM_AW'(SUM_DEPTH - 1));

   // shared arithmetic: reciprocal divide and word-base multiply
   assign div_prod  = PROD_W'(id_ff) * PROD_W'(RECIP);
   assign div_quot  = div_prod >> DIV_SH;
   assign wmul      = MUL_W'(wext_ff) * MUL_W'(WORD_BITS);
   assign rem_full  = id_ff - ID_W'(wmul);

   assign wext_sum  = wext_ff[WEXT_W-1 -: SUM_AW];
   assign bit_sel   = (state_ff == S_WRD_CHK) ? fz_wrd_idx : bit_ff;
   assign bit_mask  = WORD_BITS'(1) << bit_sel;
   assign word_set  = bm_rdata | bit_mask;
   assign word_clr  = bm_rdata & ~bit_mask;
   assign slot_mask = SUM_BITS'(1) << wext_ff[SUM_SEL_W-1:0];
   assign cur_bit   = |(bm_rdata & bit_mask);

   // reset pattern: reserved blocks and the tail past the last block are set
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         init_word[b] = ((base_ff + BASE_W'(b)) >= BASE_W'(EFF));
      end
      for (int j = 0; j < SUM_BITS; j++) begin
         init_sum[j] = ({1'b0, SUM_AW'(clr_ff), SUM_SEL_W'(j)} >= (WEXT_W + 1)'(FFW));
      end
   end

   // response counts, truncated to the port widths
   assign free_full = CNT_W'(TOTAL_BLOCKS) - cnt_ff;
   assign used_ext  = (CNT_W + USED_W)'(cnt_ff);
   assign free_ext  = (CNT_W + FREE_W)'(free_full);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == WIDX_W'(NUM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_tuser))
                  CMD_ALLOC: state_in = S_SUM_RD;
                  CMD_CLAIM,
                  CMD_FREE:  state_in = in_range ? S_DIV : S_FIN;
                  default:   state_in = S_FIN;
               endcase
            end
         end
         S_DIV:     state_in = S_REM;
         S_REM:     state_in = S_UPD;
         S_UPD:     state_in = S_FIN;
         S_SUM_RD:  state_in = S_SUM_CHK;
         S_SUM_CHK: begin
            if (fz_sum_found) begin
               state_in = S_WRD_RD;
            end else if (scan_last) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SUM_RD;
            end
         end
         S_WRD_RD:  state_in = S_WRD_CHK;
         S_WRD_CHK: state_in = S_FIN;
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      clr_in       = clr_ff;
      base_in      = base_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      wext_in      = wext_ff;
      bit_in       = bit_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      scan_in      = scan_ff;
      hint_in      = hint_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      bm_we        = 1'b0;
      bm_addr      = WIDX_W'(wext_ff);
      bm_wdata     = word_set;
      sum_we       = 1'b0;
      sum_addr     = wext_sum;
      sum_wdata    = sum_rdata | slot_mask;
      req_tready   = (state_ff == S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            req_tready = 1'b0;
            bm_we      = 1'b1;
            bm_addr    = clr_ff;
            bm_wdata   = init_word;
            sum_we     = ({1'b0, clr_ff} < (WIDX_W + 1)'(SUM_DEPTH));
            sum_addr   = SUM_AW'(clr_ff);
            sum_wdata  = init_sum;
            clr_in     = clr_ff + WIDX_W'(1);
            base_in    = base_ff + BASE_W'(WORD_BITS);
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_tuser);
               id_in     = req_tdata;
               scan_in   = hint_ff;
               grant_in  = '0;
               status_in = STAT_OK;
               if ((cmd_type'(req_tuser) == CMD_CLAIM || cmd_type'(req_tuser) == CMD_FREE)
                   && !in_range) begin
                  status_in = STAT_RANGE;
               end
            end
         end
         S_DIV: begin
            wext_in = WEXT_W'(div_quot);
         end
         S_REM: begin
            // bitmap and summary reads go out at the word index
            bit_in = BIT_W'(rem_full);
         end
         S_UPD: begin
            if (cmd_ff == CMD_CLAIM) begin
               if (cur_bit) begin
                  status_in = STAT_IN_USE;
               end else begin
                  bm_we    = 1'b1;
                  bm_wdata = word_set;
                  cnt_in   = cnt_ff + CNT_W'(1);
                  grant_in = id_ff;
                  // word just filled up: flag it in the summary
                  if (&word_set) begin
                     sum_we    = 1'b1;
                     sum_wdata = sum_rdata | slot_mask;
                  end
               end
            end else begin
               // release of a free block changes nothing
               if (cur_bit) begin
                  bm_we     = 1'b1;
                  bm_wdata  = word_clr;
                  cnt_in    = cnt_ff - CNT_W'(1);
                  sum_we    = 1'b1;
                  sum_wdata = sum_rdata & ~slot_mask;
                  if (wext_sum < hint_ff) begin
                     hint_in = wext_sum;
                  end
               end
            end
         end
         S_SUM_RD: begin
            sum_addr = scan_ff;
         end
         S_SUM_CHK: begin
            sum_addr = scan_ff;
            sum_in   = sum_rdata;
            if (fz_sum_found) begin
               wext_in = {scan_ff, fz_sum_idx};
               hint_in = scan_ff;
            end else if (scan_last) begin
               status_in = STAT_NONE_FREE;
            end else begin
               scan_in = scan_ff + SUM_AW'(1);
            end
         end
         S_WRD_RD: begin
            prod_in = BASE_W'(wmul);
         end
         S_WRD_CHK: begin
            // a non-full summary slot guarantees a clear bit here
            if (fz_wrd_found) begin
               bm_we    = 1'b1;
               bm_wdata = word_set;
               cnt_in   = cnt_ff + CNT_W'(1);
               grant_in = ID_W'(prod_ff + BASE_W'(fz_wrd_idx));
               if (&word_set) begin
                  sum_we    = 1'b1;
                  sum_wdata = sum_ff | slot_mask;
               end
            end else begin
               status_in = STAT_NONE_FREE;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PAD_W'(0), free_ext[FREE_W-1:0], used_ext[USED_W-1:0],
                               grant_ff};
               rsp_user_in  = status_ff;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         hint_ff      <= '0;
         cnt_ff       <= CNT_W'(TOTAL_BLOCKS - EFF);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         hint_ff      <= hint_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      wext_ff     <= wext_in;
      bit_ff      <= bit_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      scan_ff     <= scan_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sv/bba_checker.sv =====
// bba_checker: port-level assertions for the bitmap block allocator
// depends on bba_pkg; bound to bitmap_block_allocator at the end of this file

module bba_checker
   import bba_pkg::*;
#(
   parameter int unsigned TOTAL_BLOCKS = TOTAL_BLOCKS_DEF
)(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // reset empties the response register and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("response or ready right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // failed commands grant nothing
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[15:0] == 16'd0)
      else $error("grant on a failed command");

   // free count follows the used count
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[48:33] == FREE_W'(32'(TOTAL_BLOCKS) - 32'(rsp_tdata[32:16])))
      else $error("free and used counts disagree");

   // every command drops req_tready in the cycle after it is accepted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a request");

endmodule

bind bitmap_block_allocator bba_checker #(.TOTAL_BLOCKS(TOTAL_BLOCKS)) u_bba_checker (.*);
